@@ src/rlerd_pkg.sv @@
// Shared types and constants for the RLE row decoder.
// No dependencies; imported by every module of the block.
package rlerd_pkg;

  localparam int LANES      = 8;
  localparam int PIX_FIELDS = 8;
  // Pixels carried by one result beat.
  localparam int GROUP      = (LANES > PIX_FIELDS) ? PIX_FIELDS : LANES;

  localparam logic [15:0] ROW_WIDTH_RESET = 16'd512;
  localparam logic [7:0]  HDR_COUNT_MASK  = 8'h7f;
  localparam int          HDR_LITERAL_BIT = 7;

  typedef enum logic [1:0] {
    ST_PIXELS = 2'd0,
    ST_TERM   = 2'd1,
    ST_ERROR  = 2'd2
  } res_status_t;

  typedef enum logic [1:0] {
    PIX_NONE  = 2'd0,
    PIX_ONE   = 2'd1,
    PIX_GROUP = 2'd2
  } pix_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        hdr_load;
    logic        row_clr;
    logic        lit_step;
    logic        grp_step;
    logic        capture;
    logic        out_load;
    pix_sel_t    out_pix;
    logic        out_from_in;
    res_status_t out_status;
    logic        out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic run_over;
    logic run_fits;
    logic run_one;
    logic out_free;
  } dp_stat_t;

endpackage

@@ src/rlerd_ctrl.sv @@
// Controller of the RLE row decoder: decode mode and beat sequencing.
// Depends on rlerd_pkg; drives the datapath through dp_cmd_t.
module rlerd_ctrl
  import rlerd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last_byte,
  input  logic     hdr_literal,
  input  dp_stat_t stat,
  output logic     in_stall,
  output dp_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    M_HEADER,
    M_LITERAL,
    M_REPEAT,
    M_IGNORE
  } mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic   last_r, last_nxt;
  logic   accept;

  assign in_stall = !((state_r == S_IDLE) && stat.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.out_pix    = PIX_NONE;
    cmd.out_status = ST_PIXELS;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_last_byte;
          case (mode_r)
            M_HEADER: begin
              if (stat.count_zero || stat.run_over) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = stat.count_zero ? ST_TERM : ST_ERROR;
                cmd.out_last   = 1'b1;
                mode_nxt       = in_last_byte ? M_HEADER : M_IGNORE;
                cmd.row_clr    = in_last_byte;
              end else if (in_last_byte) begin
                // Row data ends right after a header.
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_ERROR;
                cmd.out_last   = 1'b1;
                cmd.row_clr    = 1'b1;
                mode_nxt       = M_HEADER;
              end else begin
                cmd.hdr_load = 1'b1;
                mode_nxt     = hdr_literal ? M_LITERAL : M_REPEAT;
              end
            end
            M_LITERAL: begin
              cmd.out_load    = 1'b1;
              cmd.out_pix     = PIX_ONE;
              cmd.out_from_in = 1'b1;
              cmd.out_status  = in_last_byte ? ST_ERROR : ST_PIXELS;
              cmd.out_last    = 1'b1;
              cmd.lit_step    = 1'b1;
              cmd.row_clr     = in_last_byte;
              mode_nxt        = (stat.run_one || in_last_byte) ? M_HEADER : M_LITERAL;
            end
            M_REPEAT: begin
              cmd.out_load    = 1'b1;
              cmd.out_pix     = PIX_GROUP;
              cmd.out_from_in = 1'b1;
              cmd.grp_step    = 1'b1;
              cmd.capture     = 1'b1;
              if (stat.run_fits) begin
                cmd.out_status = in_last_byte ? ST_ERROR : ST_PIXELS;
                cmd.out_last   = 1'b1;
                cmd.row_clr    = in_last_byte;
                mode_nxt       = M_HEADER;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            default: begin
              if (in_last_byte) begin
                cmd.row_clr = 1'b1;
                mode_nxt    = M_HEADER;
              end
            end
          endcase
        end
      end
      S_EMIT: begin
        // Remaining groups of a long repeat run, one beat at a time.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_pix  = PIX_GROUP;
          cmd.grp_step = 1'b1;
          if (stat.run_fits) begin
            cmd.out_status = last_r ? ST_ERROR : ST_PIXELS;
            cmd.out_last   = 1'b1;
            cmd.row_clr    = last_r;
            mode_nxt       = M_HEADER;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_HEADER;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

@@ src/rlerd_dpath.sv @@
// Datapath of the RLE row decoder: row width, counters, value and output register.
// Depends on rlerd_pkg; obeys dp_cmd_t from rlerd_ctrl.
module rlerd_dpath
  import rlerd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [15:0]                 cfg_row_width,
  input  logic [7:0]                  in_data_byte,
  input  dp_cmd_t                     cmd,
  input  logic                        out_stall,
  output dp_stat_t                    stat,
  output logic                        out_valid,
  output logic [PIX_FIELDS-1:0][7:0]  out_pixels,
  output logic [3:0]                  out_pixel_count,
  output logic [1:0]                  out_status,
  output logic                        out_last_result
);

  localparam logic [6:0] GROUP_W7 = 7'(GROUP);
  localparam logic [3:0] GROUP_W4 = 4'(GROUP);

  logic [15:0] row_width_r;
  logic [15:0] pixels_done_r;
  logic [6:0]  run_r;
  logic [7:0]  value_r;
  logic        out_valid_r;
  logic [PIX_FIELDS-1:0][7:0] pix_r, pix_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [1:0]  status_r;
  logic        last_r;

  logic [6:0]  hdr_count;
  logic [16:0] run_end;
  logic [3:0]  take;
  logic [7:0]  src_value;

  assign hdr_count = 7'(in_data_byte & HDR_COUNT_MASK);
  assign run_end   = {1'b0, pixels_done_r} + {10'd0, hdr_count};
  assign take      = stat.run_fits ? run_r[3:0] : GROUP_W4;
  assign src_value = cmd.out_from_in ? in_data_byte : value_r;

  assign stat.count_zero = (hdr_count == 7'd0);
  assign stat.run_over   = run_end > {1'b0, row_width_r};
  assign stat.run_fits   = run_r <= GROUP_W7;
  assign stat.run_one    = run_r == 7'd1;
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    case (cmd.out_pix)
      PIX_ONE:   count_nxt = 4'd1;
      PIX_GROUP: count_nxt = take;
      default:   count_nxt = 4'd0;
    endcase
    for (int i = 0; i < PIX_FIELDS; i++) begin
      pix_nxt[i] = (4'(i) < count_nxt) ? src_value : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= ROW_WIDTH_RESET;
      pixels_done_r <= '0;
      run_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_width_r <= cfg_row_width;
      end
      if (cmd.row_clr) begin
        pixels_done_r <= '0;
        run_r         <= '0;
      end else if (cmd.hdr_load) begin
        pixels_done_r <= run_end[15:0];
        run_r         <= hdr_count;
      end else if (cmd.lit_step) begin
        run_r <= run_r - 7'd1;
      end else if (cmd.grp_step) begin
        run_r <= run_r - {3'd0, take};
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_r <= in_data_byte;
    end
    if (cmd.out_load) begin
      pix_r    <= pix_nxt;
      count_r  <= count_nxt;
      status_r <= cmd.out_status;
      last_r   <= cmd.out_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixels      = pix_r;
  assign out_pixel_count = count_r;
  assign out_status      = status_r;
  assign out_last_result = last_r;

endmodule

@@ src/rle_row_decoder_8bit.sv @@
// Latency: a result beat appears the cycle after the byte that causes it is taken.
// Throughput: header and literal bytes are taken as they come while the output is free; a
// repeat byte of count n holds the input until its ceil(n/8) groups are sent, one group a cycle
// while out_stall is low. A header byte that ends nothing gives no beat; nor do ignored bytes.
// Reset (rst_n low, synchronous): row width 512, decoder awaits a run header, no beat pending.
module rle_row_decoder_8bit
  import rlerd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_row_width,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_0,
  output logic [7:0]  out_pixel_1,
  output logic [7:0]  out_pixel_2,
  output logic [7:0]  out_pixel_3,
  output logic [7:0]  out_pixel_4,
  output logic [7:0]  out_pixel_5,
  output logic [7:0]  out_pixel_6,
  output logic [7:0]  out_pixel_7,
  output logic [3:0]  out_pixel_count,
  output logic [1:0]  out_status,
  output logic        out_last_result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [PIX_FIELDS-1:0][7:0] pixels;

  rlerd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .hdr_literal  (in_data_byte[HDR_LITERAL_BIT]),
    .stat         (stat),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  rlerd_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_row_width   (cfg_row_width),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .out_stall       (out_stall),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_pixels      (pixels),
    .out_pixel_count (out_pixel_count),
    .out_status      (out_status),
    .out_last_result (out_last_result)
  );

  assign out_pixel_0 = pixels[0];
  assign out_pixel_1 = pixels[1];
  assign out_pixel_2 = pixels[2];
  assign out_pixel_3 = pixels[3];
  assign out_pixel_4 = pixels[4];
  assign out_pixel_5 = pixels[5];
  assign out_pixel_6 = pixels[6];
  assign out_pixel_7 = pixels[7];

endmodule

@@ src/rlerd_checker.sv @@
// Port-level checks for the RLE row decoder, bound to the top level.
// Depends on rlerd_pkg and the ports of rle_row_decoder_8bit.
module rlerd_checker
  import rlerd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pixel_0,
  input logic [7:0] out_pixel_7,
  input logic [3:0] out_pixel_count,
  input logic [1:0] out_status,
  input logic       out_last_result
);

  // A stalled beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_count)
      && $stable(out_status) && $stable(out_pixel_0) && $stable(out_last_result))
    else $error("stalled result beat changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel_count <= 4'(GROUP))
    else $error("pixel count exceeds group size");

  // A terminator or error closes the beats of its byte.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_PIXELS |-> out_last_result)
    else $error("status beat not marked last");

  a_term_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TERM |-> out_pixel_count == 4'd0)
    else $error("terminator beat carries pixels");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_count != 4'd8 |-> out_pixel_7 == 8'd0
      && (out_pixel_count != 4'd0 || out_pixel_0 == 8'd0))
    else $error("pixel field beyond count not zero");

endmodule

bind rle_row_decoder_8bit rlerd_checker u_rlerd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_0     (out_pixel_0),
  .out_pixel_7     (out_pixel_7),
  .out_pixel_count (out_pixel_count),
  .out_status      (out_status),
  .out_last_result (out_last_result)
);
